/* design/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants of the bezier point and coverage unit
// ----------------------------------------------------------------------------
package bpc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_e;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = 3;

  // reset coordinates in register index order
  localparam int unsigned REG_RESET [NUM_REGS] = '{100, 100, 200, 120, 300, 140, 400, 160};

  // coverage math
  localparam int unsigned FRAC8_W = 8;
  localparam int unsigned D2_W = 16;
  localparam int unsigned SQ_W = 32;
  localparam int unsigned ROOT_W = 17;
  localparam logic [D2_W-1:0] COV_SCALE = 16'd65025;  // 255 squared
  localparam logic [ROOT_W-1:0] COV_FULL = 17'd65280; // 255 * 256
  localparam int unsigned SQRT_ITERS = 16;
  localparam int unsigned SQRT_STEPS = 4;

  // per-stage load enables of one interpolation axis
  typedef struct packed {
    logic lvl1;
    logic lvl2;
    logic lvl3;
  } axis_en_t;

  // per-stage load enables of the distance front end
  typedef struct packed {
    logic sq;
    logic scale;
  } dist_en_t;

endpackage

/* design/bezier_point_with_coverage_unit.sv */
// ----------------------------------------------------------------------------
// bezier_point_with_coverage_unit
// cubic bezier point generator with pixel coverage weight
// ----------------------------------------------------------------------------
// usage:
//   load the four control points through the write port (index 0..7 is
//   p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y) while the unit is idle,
//   then stream curve parameters t on the input channel (q1.F, one = 1 << F,
//   larger values saturate to one). every input transfer yields exactly one
//   output transfer: the point in q.8 and its coverage weight, in order.
// throughput: one item per cycle, sustained while the output is not stalled.
// stages: three of interpolation levels, two of distance math, four of square
//   root (four root bits each) and one for the weight.
// stall: each stage holds while the one after it is full and stalled, so
//   empty stages still fill and input keeps flowing until the pipe is full.
// reset: control points return to their reset coordinates and all stages
//   are emptied; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bezier_point_with_coverage_unit #(
  parameter int COORD_BITS      = 10,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [bpc_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_BITS-1:0]              cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [PARAM_FRAC_BITS:0]           curve_param_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [COORD_BITS+7:0]              point_x_q8_o,
  output logic [COORD_BITS+7:0]              point_y_q8_o,
  output logic [7:0]                         coverage_weight_o
);

  localparam int C    = COORD_BITS;
  localparam int F    = PARAM_FRAC_BITS;
  localparam int NSTG = 10;
  // stage positions
  localparam int S_L1   = 0;
  localparam int S_L2   = 1;
  localparam int S_L3   = 2;
  localparam int S_SQ   = 3;
  localparam int S_SCL  = 4;
  localparam int S_RT0  = 5;
  localparam int S_WGT  = 9;
  localparam int NSQ    = bpc_pkg::SQRT_ITERS / bpc_pkg::SQRT_STEPS;
  localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

  // control point registers
  logic [C-1:0] pt_q [bpc_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpc_pkg::NUM_REGS; i++) begin
        pt_q[i] <= C'(bpc_pkg::REG_RESET[i]);
      end
    end else if (cfg_we_i) begin
      case (bpc_pkg::reg_idx_e'(cfg_index_i))
        bpc_pkg::REG_P0_X: pt_q[bpc_pkg::REG_P0_X] <= cfg_data_i;
        bpc_pkg::REG_P0_Y: pt_q[bpc_pkg::REG_P0_Y] <= cfg_data_i;
        bpc_pkg::REG_P1_X: pt_q[bpc_pkg::REG_P1_X] <= cfg_data_i;
        bpc_pkg::REG_P1_Y: pt_q[bpc_pkg::REG_P1_Y] <= cfg_data_i;
        bpc_pkg::REG_P2_X: pt_q[bpc_pkg::REG_P2_X] <= cfg_data_i;
        bpc_pkg::REG_P2_Y: pt_q[bpc_pkg::REG_P2_Y] <= cfg_data_i;
        bpc_pkg::REG_P3_X: pt_q[bpc_pkg::REG_P3_X] <= cfg_data_i;
        bpc_pkg::REG_P3_Y: pt_q[bpc_pkg::REG_P3_Y] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NSTG-1:0] valid_q, valid_d, adv;

  always_comb begin
    adv[NSTG-1] = !valid_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NSTG; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o = adv[0];

  // saturate t to one
  logic [F:0] t_sat;
  assign t_sat = (curve_param_i > T_ONE) ? T_ONE : curve_param_i;

  // interpolation, one instance per axis
  bpc_pkg::axis_en_t axis_en;
  logic [C+7:0]      x_q8, y_q8;

  assign axis_en = '{lvl1: adv[S_L1], lvl2: adv[S_L2], lvl3: adv[S_L3]};

  bpc_axis #(.COORD_BITS(C), .PARAM_FRAC_BITS(F)) u_axis_x (
    .clk_i (clk_i),
    .en_i  (axis_en),
    .t_i   (t_sat),
    .c0_i  (pt_q[bpc_pkg::REG_P0_X]),
    .c1_i  (pt_q[bpc_pkg::REG_P1_X]),
    .c2_i  (pt_q[bpc_pkg::REG_P2_X]),
    .c3_i  (pt_q[bpc_pkg::REG_P3_X]),
    .q8_o  (x_q8)
  );

  bpc_axis #(.COORD_BITS(C), .PARAM_FRAC_BITS(F)) u_axis_y (
    .clk_i (clk_i),
    .en_i  (axis_en),
    .t_i   (t_sat),
    .c0_i  (pt_q[bpc_pkg::REG_P0_Y]),
    .c1_i  (pt_q[bpc_pkg::REG_P1_Y]),
    .c2_i  (pt_q[bpc_pkg::REG_P2_Y]),
    .c3_i  (pt_q[bpc_pkg::REG_P3_Y]),
    .q8_o  (y_q8)
  );

  // point carried alongside the coverage math
  logic [C+7:0] x_pipe_q [S_SQ:S_WGT];
  logic [C+7:0] y_pipe_q [S_SQ:S_WGT];

  always_ff @(posedge clk_i) begin
    if (adv[S_SQ]) begin
      x_pipe_q[S_SQ] <= x_q8;
      y_pipe_q[S_SQ] <= y_q8;
    end
    for (int k = S_SQ + 1; k <= S_WGT; k++) begin
      if (adv[k]) begin
        x_pipe_q[k] <= x_pipe_q[k-1];
        y_pipe_q[k] <= y_pipe_q[k-1];
      end
    end
  end

  // squared distance, scaled
  bpc_pkg::dist_en_t        dist_en;
  logic [bpc_pkg::SQ_W-1:0] sq_n [NSQ+1];
  logic [bpc_pkg::SQ_W-1:0] sq_r [NSQ+1];

  assign dist_en = '{sq: adv[S_SQ], scale: adv[S_SCL]};

  bpc_dist u_dist (
    .clk_i    (clk_i),
    .en_i     (dist_en),
    .frac_x_i (x_q8[7:0]),
    .frac_y_i (y_q8[7:0]),
    .n_o      (sq_n[0])
  );

  assign sq_r[0] = '0;

  // square root, four root bits per stage
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    bpc_sqrt_step #(
      .TOP_ITER (bpc_pkg::SQRT_ITERS - 1 - g * bpc_pkg::SQRT_STEPS),
      .STEPS    (bpc_pkg::SQRT_STEPS)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (adv[S_RT0+g]),
      .n_i   (sq_n[g]),
      .r_i   (sq_r[g]),
      .n_o   (sq_n[g+1]),
      .r_o   (sq_r[g+1])
    );
  end

  // ceiling of the root, then weight
  logic [bpc_pkg::ROOT_W-1:0] root_ceil, wgt_diff;
  logic [7:0]                 weight_d, weight_q;

  always_comb begin
    root_ceil = sq_r[NSQ][bpc_pkg::ROOT_W-1:0] + bpc_pkg::ROOT_W'(sq_n[NSQ] != '0);
    wgt_diff  = bpc_pkg::COV_FULL - root_ceil;
    if (root_ceil >= bpc_pkg::COV_FULL) begin
      weight_d = '0;
    end else begin
      weight_d = wgt_diff[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_WGT]) begin
      weight_q <= weight_d;
    end
  end

  assign out_valid_o       = valid_q[S_WGT];
  assign point_x_q8_o      = x_pipe_q[S_WGT];
  assign point_y_q8_o      = y_pipe_q[S_WGT];
  assign coverage_weight_o = weight_q;

  // an input transfer always lands in the first stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[S_L1])
    else $error("input transfer lost at first stage");

  // while the output stalls, input is taken only if some stage is empty
  a_stall_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_ready_o |-> !(&valid_q))
    else $error("input taken into a full stalled pipe");

  // a stalled stage keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[S_SCL] && !adv[S_SCL] |=> valid_q[S_SCL])
    else $error("stalled stage dropped its item");

  // the final root fits the weight range
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[S_WGT-1] |-> sq_r[NSQ] < bpc_pkg::SQ_W'(bpc_pkg::COV_FULL))
    else $error("square root out of range");

endmodule

/* design/bpc_axis.sv */
// ----------------------------------------------------------------------------
// bpc_axis
// three-stage de casteljau interpolation of one coordinate axis
// ----------------------------------------------------------------------------
module bpc_axis #(
  parameter int COORD_BITS      = 10,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  bpc_pkg::axis_en_t         en_i,
  input  logic [PARAM_FRAC_BITS:0]  t_i,
  input  logic [COORD_BITS-1:0]     c0_i,
  input  logic [COORD_BITS-1:0]     c1_i,
  input  logic [COORD_BITS-1:0]     c2_i,
  input  logic [COORD_BITS-1:0]     c3_i,
  output logic [COORD_BITS+7:0]     q8_o
);

  localparam int C  = COORD_BITS;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int QW = C + F;
  localparam int DW = QW + 1;
  localparam int PW = DW + F + 2;
  localparam int LW = C + F + 3;
  localparam int SH = F - 8;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);
  localparam logic [QW:0] RND8 = ((QW+1)'(1) << SH) >> 1;

  // first level: integer endpoints, exact
  function automatic logic [QW-1:0] lerp1(input logic [C-1:0] a, input logic [C-1:0] b,
                                          input logic [F:0] t);
    logic signed [C:0]    diff;
    logic signed [LW-1:0] prod;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    return QW'(prod + $signed({3'b000, a, {F{1'b0}}}));
  endfunction

  // later levels: round to nearest, ties up
  function automatic logic [QW-1:0] lerp(input logic [QW-1:0] a, input logic [QW-1:0] b,
                                         input logic [F:0] t);
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] step;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    step = (prod + HALF) >>> F;
    return QW'(step + $signed({{(PW-QW){1'b0}}, a}));
  endfunction

  logic [QW-1:0] b0_q, b1_q, b2_q;
  logic [QW-1:0] d0_q, d1_q;
  logic [F:0]    t1_q, t2_q;
  logic [QW-1:0] v;
  logic [QW:0]   vr;

  always_ff @(posedge clk_i) begin
    if (en_i.lvl1) begin
      b0_q <= lerp1(c0_i, c1_i, t_i);
      b1_q <= lerp1(c1_i, c2_i, t_i);
      b2_q <= lerp1(c2_i, c3_i, t_i);
      t1_q <= t_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.lvl2) begin
      d0_q <= lerp(b0_q, b1_q, t1_q);
      d1_q <= lerp(b1_q, b2_q, t1_q);
      t2_q <= t1_q;
    end
  end

  // last level and rounding to nearest, ties up, into q.8
  always_comb begin
    v  = lerp(d0_q, d1_q, t2_q);
    vr = ({1'b0, v} + RND8) >> SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.lvl3) begin
      q8_o <= vr[C+7:0];
    end
  end

endmodule

/* design/bpc_dist.sv */
// ----------------------------------------------------------------------------
// bpc_dist
// squared distance to the pixel centre, scaled by 255 squared
// ----------------------------------------------------------------------------
module bpc_dist (
  input  logic                              clk_i,
  input  bpc_pkg::dist_en_t                 en_i,
  input  logic [bpc_pkg::FRAC8_W-1:0]       frac_x_i,
  input  logic [bpc_pkg::FRAC8_W-1:0]       frac_y_i,
  output logic [bpc_pkg::SQ_W-1:0]          n_o
);

  logic signed [8:0]           dx, dy;
  logic signed [17:0]          sqx, sqy;
  logic [bpc_pkg::D2_W-1:0]    d2_q;

  always_comb begin
    dx  = $signed({1'b0, frac_x_i}) - 9'sd128;
    dy  = $signed({1'b0, frac_y_i}) - 9'sd128;
    sqx = dx * dx;
    sqy = dy * dy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      d2_q <= sqx[15:0] + sqy[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.scale) begin
      n_o <= bpc_pkg::SQ_W'(d2_q * bpc_pkg::COV_SCALE);
    end
  end

endmodule

/* design/bpc_sqrt_step.sv */
// ----------------------------------------------------------------------------
// bpc_sqrt_step
// one registered slice of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module bpc_sqrt_step #(
  parameter int TOP_ITER = 15,
  parameter int STEPS    = 4
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [bpc_pkg::SQ_W-1:0]   n_i,
  input  logic [bpc_pkg::SQ_W-1:0]   r_i,
  output logic [bpc_pkg::SQ_W-1:0]   n_o,
  output logic [bpc_pkg::SQ_W-1:0]   r_o
);

  logic [bpc_pkg::SQ_W-1:0] n_d, r_d, bitv;

  always_comb begin
    n_d = n_i;
    r_d = r_i;
    for (int k = 0; k < STEPS; k++) begin
      bitv = bpc_pkg::SQ_W'(1) << (2 * (TOP_ITER - k));
      if (n_d >= r_d + bitv) begin
        n_d = n_d - (r_d + bitv);
        r_d = (r_d >> 1) + bitv;
      end else begin
        r_d = r_d >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o <= n_d;
      r_o <= r_d;
    end
  end

endmodule

/* test/tb_bezier_point_with_coverage_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bezier_point_with_coverage_unit
// self-checking bench for the cubic bezier point and coverage unit
// ----------------------------------------------------------------------------
// streams curve parameters through the input channel under several sets of
// control points, predicts each curve point and its coverage weight with an
// independent fixed-point model of de casteljau's algorithm, and compares
// every output transfer in order. both channels idle at random; control
// points are reloaded only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_bezier_point_with_coverage_unit;

  localparam int COORD_BITS      = 10;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int POINT_W         = COORD_BITS + 8;
  localparam int Q8_SHIFT        = PARAM_FRAC_BITS - 8;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
  localparam int PARAM_ONE       = 1 << PARAM_FRAC_BITS;
  localparam int PARAM_MAX       = (1 << (PARAM_FRAC_BITS + 1)) - 1;
  localparam longint unsigned T_ONE = 64'd1 << PARAM_FRAC_BITS;

  // coverage constants
  localparam longint PIXEL_HALF          = 128;
  localparam longint unsigned COV_SQ     = 65025;  // 255 squared
  localparam longint unsigned COV_TOP    = 65280;  // 255 * 256

  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 12;  // a bit past the pipeline latency
  localparam int NUM_RAND_SETS = 6;
  localparam int ITEMS_PER_SET = 80;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [PARAM_FRAC_BITS:0] param_t;
  typedef logic [POINT_W-1:0]       point_t;
  typedef logic [7:0]               weight_t;

  typedef struct {
    point_t  x;
    point_t  y;
    weight_t w;
  } curve_point_t;

  // --------------------------------------------------------------------------
  // expected curve points, in input transfer order
  // --------------------------------------------------------------------------
  class point_scoreboard;
    coord_t       coord [bpc_pkg::NUM_REGS];
    curve_point_t pending_points [$];
    int unsigned  errors;

    function new();
      foreach (coord[i]) coord[i] = coord_t'(bpc_pkg::REG_RESET[i]);
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    function int unsigned pending();
      return pending_points.size();
    endfunction

    function void set_coord(bpc_pkg::reg_idx_e idx, coord_t val);
      coord[idx] = val;
    endfunction

    // one interpolation level, rounded to nearest with ties up
    function longint unsigned lerp_q(longint unsigned a, longint unsigned b,
                                     longint unsigned t);
      return (a * (T_ONE - t) + b * t + (T_ONE >> 1)) >> PARAM_FRAC_BITS;
    endfunction

    function point_t axis_q8(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                             longint unsigned t);
      longint unsigned a0, a1, a2, a3, b0, b1, b2, d0, d1, v;
      a0 = 64'(c0) << PARAM_FRAC_BITS;
      a1 = 64'(c1) << PARAM_FRAC_BITS;
      a2 = 64'(c2) << PARAM_FRAC_BITS;
      a3 = 64'(c3) << PARAM_FRAC_BITS;
      b0 = lerp_q(a0, a1, t);
      b1 = lerp_q(a1, a2, t);
      b2 = lerp_q(a2, a3, t);
      d0 = lerp_q(b0, b1, t);
      d1 = lerp_q(b1, b2, t);
      v  = lerp_q(d0, d1, t);
      if (Q8_SHIFT > 0) v = (v + (64'd1 << (Q8_SHIFT - 1))) >> Q8_SHIFT;
      return point_t'(v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // floor(255 * (1 - distance to pixel centre)), exact via ceiling root
    function weight_t weight_of(point_t x, point_t y);
      longint dx, dy;
      longint unsigned n, r, c;
      dx = longint'(x[7:0]) - PIXEL_HALF;
      dy = longint'(y[7:0]) - PIXEL_HALF;
      n  = COV_SQ * longint'(dx * dx + dy * dy);
      r  = int_sqrt(n);
      c  = (r * r == n) ? r : r + 1;
      if (c >= COV_TOP) return '0;
      return weight_t'((COV_TOP - c) >> 8);
    endfunction

    function curve_point_t predict_point(param_t raw);
      longint unsigned t;
      curve_point_t p;
      t = (64'(raw) > T_ONE) ? T_ONE : 64'(raw);
      p.x = axis_q8(coord[bpc_pkg::REG_P0_X], coord[bpc_pkg::REG_P1_X],
                    coord[bpc_pkg::REG_P2_X], coord[bpc_pkg::REG_P3_X], t);
      p.y = axis_q8(coord[bpc_pkg::REG_P0_Y], coord[bpc_pkg::REG_P1_Y],
                    coord[bpc_pkg::REG_P2_Y], coord[bpc_pkg::REG_P3_Y], t);
      p.w = weight_of(p.x, p.y);
      return p;
    endfunction

    function void note_param(param_t raw);
      pending_points.push_back(predict_point(raw));
    endfunction

    task check_point(point_t x, point_t y, weight_t w);
      curve_point_t e;
      if (pending_points.size() == 0) begin
        report($sformatf("output with nothing pending x=%0d y=%0d w=%0d", x, y, w));
        return;
      end
      e = pending_points.pop_front();
      if (x !== e.x) report($sformatf("point_x_q8 got %0d want %0d", x, e.x));
      if (y !== e.y) report($sformatf("point_y_q8 got %0d want %0d", y, e.y));
      if (w !== e.w) report($sformatf("coverage_weight got %0d want %0d", w, e.w));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut signals
  // --------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_we      = 1'b0;
  bpc_pkg::reg_idx_e cfg_index   = bpc_pkg::REG_P0_X;
  coord_t            cfg_data    = '0;
  logic              in_valid    = 1'b0;
  param_t            curve_param = '0;
  logic              out_ready   = 1'b0;

  logic     in_ready_o;
  logic     out_valid_o;
  point_t   point_x_q8_o;
  point_t   point_y_q8_o;
  weight_t  coverage_weight_o;

  point_scoreboard sb = new();

  // sender stretch with no gaps at all
  bit tx_burst = 1'b0;

  param_t param_list [$];
  coord_t pts [bpc_pkg::NUM_REGS];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bezier_point_with_coverage_unit #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .curve_param_i     (curve_param),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .point_x_q8_o      (point_x_q8_o),
    .point_y_q8_o      (point_y_q8_o),
    .coverage_weight_o (coverage_weight_o)
  );

  // --------------------------------------------------------------------------
  // transfer monitor: values read here are the ones from before the edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) sb.note_param(curve_param);
      if (out_valid_o && out_ready) sb.check_point(point_x_q8_o, point_y_q8_o, coverage_weight_o);
    end
  end

  // --------------------------------------------------------------------------
  // receiver back-pressure: mostly short stalls, a few long ones, and now and
  // then a long stretch with ready held high
  // --------------------------------------------------------------------------
  initial begin
    int run, stall, r;
    forever begin
      r = $urandom_range(0, 99);
      run = (r < 15) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      r = $urandom_range(0, 99);
      if (r < 60)      stall = $urandom_range(1, 2);
      else if (r < 92) stall = $urandom_range(3, 8);
      else             stall = $urandom_range(20, 50);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks; each is entered right after a rising edge
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high across back-to-back items; only sender_gap and drain lower it
  task automatic send_param(input param_t t);
    in_valid    <= 1'b1;
    curve_param <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic sender_gap();
    int n;
    n = tx_burst ? 0 : pick_gap();
    if (n > 0) begin
      in_valid    <= 1'b0;
      curve_param <= param_t'($urandom_range(0, PARAM_MAX));
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_list();
    foreach (param_list[i]) begin
      send_param(param_list[i]);
      sender_gap();
    end
  endtask

  // stop sending and wait until every expected point has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all eight control coordinates on consecutive edges
  task automatic load_points();
    for (int i = 0; i < bpc_pkg::NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= bpc_pkg::reg_idx_e'(i);
      cfg_data  <= pts[i];
      sb.set_coord(bpc_pkg::reg_idx_e'(i), pts[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return coord_t'(COORD_MAX);
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // mostly the legal range, some saturating and edge values
  function automatic param_t pick_param();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return param_t'($urandom_range(0, PARAM_ONE));
    if (r < 74) return param_t'(0);
    if (r < 78) return param_t'(PARAM_ONE);
    if (r < 80) return param_t'(PARAM_ONE - 1);
    return param_t'($urandom_range(0, PARAM_MAX));
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset control points: ends of t, the midpoint, saturation above one
    param_list = '{17'd0, 17'd1, 17'd2, 17'd255, 17'd256, 17'd32767, 17'd32768,
                   17'd32769, 17'd65535, 17'd65536, 17'd65537, 17'd98304,
                   17'd131071, 17'h15555, 17'h0AAAA};
    send_list();

    // all control points at the origin
    drain();
    foreach (pts[i]) pts[i] = '0;
    load_points();
    param_list = '{17'd0, 17'd32768, 17'd65536};
    send_list();

    // all control points at the far corner
    drain();
    foreach (pts[i]) pts[i] = coord_t'(COORD_MAX);
    load_points();
    param_list = '{17'd0, 17'd65536, 17'd131071};
    send_list();

    // alternating extremes, x and y in opposite phase
    drain();
    pts = '{coord_t'(0), coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(0),
            coord_t'(0), coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(0)};
    load_points();
    param_list = '{17'd16384, 17'd32768, 17'd49152};
    send_list();

    // straight line 0..3: lands on pixel centres, full weight
    drain();
    pts = '{coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(1),
            coord_t'(2), coord_t'(2), coord_t'(3), coord_t'(3)};
    load_points();
    param_list = '{17'd10923, 17'd32768};
    send_list();

    // random control point sets, each with a random stream of t
    for (int s = 0; s < NUM_RAND_SETS; s++) begin
      drain();
      foreach (pts[i]) pts[i] = rand_coord();
      load_points();
      tx_burst = (s % 3 == 1);
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        if (s == 2 && k == ITEMS_PER_SET / 2) drain();  // hold off until empty
        send_param(pick_param());
        sender_gap();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/bpc_pkg.sv
design/bpc_axis.sv
design/bpc_dist.sv
design/bpc_sqrt_step.sv
design/bezier_point_with_coverage_unit.sv
test/tb_bezier_point_with_coverage_unit.sv
